// ===== src/qbte_pkg.sv =====
// ============================================================================
// Quintic blend trajectory evaluator package
// Shared types, constants, register indexes and fixed-point helper functions.
// ============================================================================
`default_nettype none

package qbte_pkg;

    // Default joint count; the top level may override it (1..8).
    localparam int MAX_JOINTS_DEF = 8;

    // Joint count and joint counter comparisons are done at this width.
    localparam int CNT_W = 5;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_TICK       = 3'd0,
        REG_INVERSE_DURATION = 3'd1,
        REG_SPEED_SCALE      = 3'd2,
        REG_BLEND_DIAMETER   = 3'd3,
        REG_ACTIVE_JOINTS    = 3'd4
    } cfg_reg_t;

    localparam logic [3:0] ACTIVE_JOINTS_RST = 4'd7;

    // Transaction modes on the sample channel.
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    // Shared multiplier widths.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Fixed-point constants.
    localparam logic [63:0]        ONE30 = 64'd1 << 30;
    localparam logic signed [63:0] BIG   = 64'sd1 <<< 62;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SIGMA,
        ST_JOINT,
        ST_ROOT,
        ST_EMIT
    } state_t;

    // One joint's blend coefficients, stored as one memory word.
    typedef struct packed {
        logic signed [31:0] start_offset;
        logic signed [31:0] start_slope;
        logic signed [31:0] end_offset;
        logic signed [31:0] slope_difference;
    } coef_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end
        else if (x < -64'sd2147483648) begin
            r = 32'sh80000000;
        end
        else begin
            r = 32'(x);
        end
        return r;
    endfunction

    // Finishes floor(a * scale / 2^16) from the two partial products of the
    // upper 32 bits and the lower 16 bits of a. Operands whose upper part
    // does not fit 32 bits return a large marker of the same sign, if scale != 0.
    function automatic logic signed [63:0] mul_q16_fix(
        input logic signed [63:0] a,
        input logic signed [63:0] hi_prod,
        input logic signed [63:0] lo_prod,
        input logic [30:0]        scale
    );
        logic               big_pos;
        logic               big_neg;
        logic signed [63:0] r;
        big_pos = !a[63] && (|a[62:47]);
        big_neg = a[63] && !(&a[62:47]);
        if (scale == 31'd0) begin
            r = 64'sd0;
        end
        else if (big_pos) begin
            r = BIG;
        end
        else if (big_neg) begin
            r = -BIG;
        end
        else begin
            r = hi_prod + (lo_prod >>> 16);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/qbte_sample_if.sv =====
// ============================================================================
// Sample channel interface
// Valid/ready channel carrying load and evaluate transactions.
// ============================================================================
`default_nettype none

interface qbte_sample_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [2:0]         joint_index;
    logic signed [31:0] start_position;
    logic signed [31:0] start_heading;
    logic signed [31:0] end_heading;
    logic signed [31:0] end_position;
    logic [31:0]        sample_tick;

    modport source (
        output valid, mode, joint_index, start_position, start_heading,
               end_heading, end_position, sample_tick,
        input  ready
    );

    modport sink (
        input  valid, mode, joint_index, start_position, start_heading,
               end_heading, end_position, sample_tick,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/qbte_result_if.sv =====
// ============================================================================
// Result channel interface
// Valid/ready channel carrying one joint's commanded motion per transaction.
// ============================================================================
`default_nettype none

interface qbte_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         joint_number;
    logic signed [31:0] joint_position;
    logic signed [31:0] joint_velocity;
    logic signed [31:0] joint_acceleration;
    logic [31:0]        path_speed;
    logic [31:0]        path_acceleration;
    logic               last;

    modport source (
        output valid, joint_number, joint_position, joint_velocity,
               joint_acceleration, path_speed, path_acceleration, last,
        input  ready
    );

    modport sink (
        input  valid, joint_number, joint_position, joint_velocity,
               joint_acceleration, path_speed, path_acceleration, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/qbte_mul.sv =====
// ============================================================================
// Shared registered multiplier
// Signed multiply with the product registered; one issue per cycle.
// ============================================================================
`default_nettype none

module qbte_mul (
    input  logic                                 clk,
    input  logic signed [qbte_pkg::MUL_A_W-1:0] a,
    input  logic signed [qbte_pkg::MUL_B_W-1:0] b,
    output logic signed [qbte_pkg::MUL_P_W-1:0] prod
);
    import qbte_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== src/qbte_coef_mem.sv =====
// ============================================================================
// Coefficient memory
// One word per joint, synchronous write, registered read.
// ============================================================================
`default_nettype none

module qbte_coef_mem #(
    parameter int DEPTH = qbte_pkg::MAX_JOINTS_DEF,
    parameter int AW    = 3
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  qbte_pkg::coef_t  wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output qbte_pkg::coef_t  rdata
);
    import qbte_pkg::*;

    coef_t mem [DEPTH];
    coef_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/qbte_isqrt.sv =====
// ============================================================================
// Iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ============================================================================
`default_nettype none

module qbte_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        busy,
    output logic [31:0] root
);
    import qbte_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        trial     = r_reg + bit_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            x_next    = value;
            r_next    = 64'd0;
            bit_next  = 64'd1 << 62;
        end
        else if (busy_reg) begin
            if (x_reg >= trial) begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign root = r_reg[31:0];

endmodule

`default_nettype wire

// ===== src/quintic_blend_trajectory_eval.sv =====
// ============================================================================
// Quintic blend trajectory evaluator
// Stores per-joint blend coefficients and evaluates position, velocity and
// acceleration of every active joint at a given time tick.
// ============================================================================
// A load transaction produces no result. An evaluate transaction
// works through the active joints one after another, and it waits
// whenever the result channel stalls: every product goes through one shared
// registered multiplier (18 products per joint), and the two path
// norms come from bit-serial square root units started after the
// last joint. Coefficients sit in a single-port-read memory, one word per
// joint; loads and evaluations never overlap, so no forwarding is needed.
// The next transaction is accepted as soon as the last result is in the
// output register.
`default_nettype none

module quintic_blend_trajectory_eval #(
    parameter int MAX_JOINTS = qbte_pkg::MAX_JOINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [qbte_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qbte_pkg::CFG_DATA_W-1:0]  cfg_data,
    qbte_sample_if.sink                       sample,
    qbte_result_if.source                     result
);
    import qbte_pkg::*;

    localparam int AW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

    // Configuration registers.
    logic [31:0] start_tick_reg;
    logic [31:0] inv_dur_reg;
    logic [30:0] speed_scale_reg;
    logic [30:0] blend_diam_reg;
    logic [3:0]  active_joints_reg;

    // Control.
    state_t           state_reg, state_next;
    logic [4:0]       step_reg, step_next;
    logic [AW-1:0]    j_reg, j_next;
    logic             out_valid_reg, out_valid_next;

    // Captured transaction.
    logic [2:0]         ld_idx_reg, ld_idx_next;
    logic signed [31:0] ld_sp_reg, ld_sp_next;
    logic signed [31:0] ld_sd_reg, ld_sd_next;
    logic signed [31:0] ld_ed_reg, ld_ed_next;
    logic signed [31:0] ld_ep_reg, ld_ep_next;
    logic [31:0]        tick_reg, tick_next;
    logic signed [47:0] m1s_reg, m1s_next;

    // Normalized time and its powers (Q30), and the blend polynomials (Q24).
    logic [30:0]        s_reg, s_next;
    logic [30:0]        pw2_reg, pw2_next;
    logic [30:0]        pw3_reg, pw3_next;
    logic [30:0]        pw4_reg, pw4_next;
    logic [30:0]        pw5_reg, pw5_next;
    logic [30:0]        pw6_reg, pw6_next;
    logic signed [31:0] pa_reg, pa_next;
    logic signed [31:0] pad_reg, pad_next;
    logic signed [31:0] padd_reg, padd_next;
    logic signed [31:0] pkb_reg, pkb_next;
    logic signed [31:0] pkbd_reg, pkbd_next;
    logic signed [31:0] pkbdd_reg, pkbdd_next;

    // Per-joint datapath.
    logic signed [33:0] x21_reg, x21_next;
    logic signed [63:0] p_reg, p_next;
    logic signed [63:0] v0_reg, v0_next;
    logic signed [63:0] a0_reg, a0_next;
    logic signed [63:0] t_reg, t_next;
    logic signed [63:0] q_reg, q_next;
    logic signed [31:0] pos_reg, pos_next;
    logic signed [31:0] vel_reg, vel_next;
    logic signed [31:0] acc_reg, acc_next;
    logic [63:0]        sumv_reg, sumv_next;
    logic [63:0]        suma_reg, suma_next;
    logic               ovv_reg, ovv_next;
    logic               ova_reg, ova_next;

    // Output register payload.
    logic [2:0]         o_joint_reg, o_joint_next;
    logic signed [31:0] o_pos_reg, o_pos_next;
    logic signed [31:0] o_vel_reg, o_vel_next;
    logic signed [31:0] o_acc_reg, o_acc_next;
    logic [31:0]        o_speed_reg, o_speed_next;
    logic [31:0]        o_accel_reg, o_accel_next;
    logic               o_last_reg, o_last_next;

    // Unit connections.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    coef_t                     mem_wdata;
    logic                      mem_re;
    coef_t                     rd;
    logic                      root_start;
    logic                      rootv_busy, roota_busy;
    logic [31:0]               rootv, roota;

    // Helpers.
    logic [CNT_W-1:0]   n_joints;
    logic [CNT_W-1:0]   j_wide;
    logic [CNT_W-1:0]   ld_idx_wide;
    logic               is_last;
    logic [31:0]        dtick;
    logic [63:0]        sig_raw;
    logic signed [47:0] m2s;
    logic [64:0]        sq_sum;
    logic signed [43:0] e1, e2, e3, e4, e5, e6;

    qbte_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    qbte_coef_mem #(
        .DEPTH (MAX_JOINTS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (j_reg),
        .rdata (rd)
    );

    qbte_isqrt u_root_speed (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (sumv_reg),
        .busy  (rootv_busy),
        .root  (rootv)
    );

    qbte_isqrt u_root_accel (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (suma_reg),
        .busy  (roota_busy),
        .root  (roota)
    );

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_tick_reg    <= 32'd0;
            inv_dur_reg       <= 32'd0;
            speed_scale_reg   <= 31'd0;
            blend_diam_reg    <= 31'd0;
            active_joints_reg <= ACTIVE_JOINTS_RST;
        end
        else if (cfg_write) begin
            case (cfg_index)
                REG_START_TICK:       start_tick_reg    <= cfg_data;
                REG_INVERSE_DURATION: inv_dur_reg       <= cfg_data;
                REG_SPEED_SCALE:      speed_scale_reg   <= cfg_data[30:0];
                REG_BLEND_DIAMETER:   blend_diam_reg    <= cfg_data[30:0];
                REG_ACTIVE_JOINTS:    active_joints_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (active_joints_reg == 4'd0) begin
            n_joints = CNT_W'(1);
        end
        else if (CNT_W'(active_joints_reg) > CNT_W'(MAX_JOINTS)) begin
            n_joints = CNT_W'(MAX_JOINTS);
        end
        else begin
            n_joints = CNT_W'(active_joints_reg);
        end
    end

    assign j_wide      = CNT_W'(j_reg);
    assign ld_idx_wide = CNT_W'(ld_idx_reg);
    assign is_last     = (j_wide + CNT_W'(1)) == n_joints;
    assign dtick       = (tick_reg > start_tick_reg) ? (tick_reg - start_tick_reg) : 32'd0;
    assign sig_raw     = prod[65:2];
    assign m2s         = 48'(prod >>> 16);
    assign e1          = 44'(s_reg);
    assign e2          = 44'(pw2_reg);
    assign e3          = 44'(pw3_reg);
    assign e4          = 44'(pw4_reg);
    assign e5          = 44'(pw5_reg);
    assign e6          = 44'(pw6_reg);

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg && !result.ready;

        ld_idx_next = ld_idx_reg;
        ld_sp_next  = ld_sp_reg;
        ld_sd_next  = ld_sd_reg;
        ld_ed_next  = ld_ed_reg;
        ld_ep_next  = ld_ep_reg;
        tick_next   = tick_reg;
        m1s_next    = m1s_reg;

        s_next     = s_reg;
        pw2_next   = pw2_reg;
        pw3_next   = pw3_reg;
        pw4_next   = pw4_reg;
        pw5_next   = pw5_reg;
        pw6_next   = pw6_reg;
        pa_next    = pa_reg;
        pad_next   = pad_reg;
        padd_next  = padd_reg;
        pkb_next   = pkb_reg;
        pkbd_next  = pkbd_reg;
        pkbdd_next = pkbdd_reg;

        x21_next  = x21_reg;
        p_next    = p_reg;
        v0_next   = v0_reg;
        a0_next   = a0_reg;
        t_next    = t_reg;
        q_next    = q_reg;
        pos_next  = pos_reg;
        vel_next  = vel_reg;
        acc_next  = acc_reg;
        sumv_next = sumv_reg;
        suma_next = suma_reg;
        ovv_next  = ovv_reg;
        ova_next  = ova_reg;

        o_joint_next = o_joint_reg;
        o_pos_next   = o_pos_reg;
        o_vel_next   = o_vel_reg;
        o_acc_next   = o_acc_reg;
        o_speed_next = o_speed_reg;
        o_accel_next = o_accel_reg;
        o_last_next  = o_last_reg;

        mul_a      = '0;
        mul_b      = '0;
        mem_we     = 1'b0;
        mem_waddr  = ld_idx_wide[AW-1:0];
        mem_wdata  = '0;
        mem_re     = 1'b0;
        root_start = 1'b0;
        sq_sum     = '0;

        sample.ready = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (sample.valid) begin
                    ld_idx_next = sample.joint_index;
                    ld_sp_next  = sample.start_position;
                    ld_sd_next  = sample.start_heading;
                    ld_ed_next  = sample.end_heading;
                    ld_ep_next  = sample.end_position;
                    tick_next   = sample.sample_tick;
                    step_next   = 5'd0;
                    state_next  = (sample.mode == MODE_EVAL) ? ST_SIGMA : ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                step_next = step_reg + 5'd1;
                case (step_reg)
                    5'd0:
                    begin
                        mul_a = MUL_A_W'(ld_sd_reg);
                        mul_b = MUL_B_W'(blend_diam_reg);
                    end
                    5'd1:
                    begin
                        mul_a    = MUL_A_W'(ld_ed_reg);
                        mul_b    = MUL_B_W'(blend_diam_reg);
                        m1s_next = 48'(prod >>> 16);
                    end
                    default:
                    begin
                        mem_we    = ld_idx_wide < CNT_W'(MAX_JOINTS);
                        mem_wdata.start_offset     = ld_sp_reg;
                        mem_wdata.start_slope      = sat32(64'(m1s_reg));
                        mem_wdata.end_offset       = sat32(64'(ld_ep_reg) - 64'(m2s));
                        mem_wdata.slope_difference = sat32(64'(m2s) - 64'(m1s_reg));
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_SIGMA:
            begin
                step_next = step_reg + 5'd1;
                case (step_reg)
                    5'd0:
                    begin
                        mul_a = MUL_A_W'(dtick);
                        mul_b = MUL_B_W'(inv_dur_reg);
                    end
                    5'd1:
                    begin
                        s_next = (sig_raw > ONE30) ? ONE30[30:0] : sig_raw[30:0];
                    end
                    5'd2:
                    begin
                        mul_a = MUL_A_W'(s_reg);
                        mul_b = MUL_B_W'(s_reg);
                    end
                    5'd3:
                    begin
                        pw2_next = prod[60:30];
                        mul_a    = MUL_A_W'(prod[60:30]);
                        mul_b    = MUL_B_W'(s_reg);
                    end
                    5'd4:
                    begin
                        pw3_next = prod[60:30];
                        mul_a    = MUL_A_W'(prod[60:30]);
                        mul_b    = MUL_B_W'(s_reg);
                    end
                    5'd5:
                    begin
                        pw4_next = prod[60:30];
                        mul_a    = MUL_A_W'(prod[60:30]);
                        mul_b    = MUL_B_W'(s_reg);
                    end
                    5'd6:
                    begin
                        pw5_next = prod[60:30];
                        mul_a    = MUL_A_W'(prod[60:30]);
                        mul_b    = MUL_B_W'(s_reg);
                    end
                    5'd7:
                    begin
                        pw6_next = prod[60:30];
                    end
                    default:
                    begin
                        // Polynomials are exact at Q31 and floored to Q24.
                        pa_next    = 32'((44'sd12 * e5 - 44'sd30 * e4 + 44'sd20 * e3) >>> 7);
                        pad_next   = 32'((44'sd60 * e4 - 44'sd120 * e3 + 44'sd60 * e2) >>> 7);
                        padd_next  = 32'((44'sd240 * e3 - 44'sd360 * e2 + 44'sd120 * e1) >>> 7);
                        pkb_next   = 32'((44'sd15 * e6 - 44'sd45 * e5 + 44'sd45 * e4
                                          - 44'sd15 * e3) >>> 7);
                        pkbd_next  = 32'((44'sd90 * e5 - 44'sd225 * e4 + 44'sd180 * e3
                                          - 44'sd45 * e2) >>> 7);
                        pkbdd_next = 32'((44'sd450 * e4 - 44'sd900 * e3 + 44'sd540 * e2
                                          - 44'sd90 * e1) >>> 7);
                        j_next     = '0;
                        sumv_next  = 64'd0;
                        suma_next  = 64'd0;
                        ovv_next   = 1'b0;
                        ova_next   = 1'b0;
                        step_next  = 5'd0;
                        state_next = ST_JOINT;
                    end
                endcase
            end

            ST_JOINT:
            begin
                // Most steps issue one product and consume the one before it.
                step_next = step_reg + 5'd1;
                case (step_reg)
                    5'd0:
                    begin
                        mem_re = 1'b1;
                    end
                    5'd1:
                    begin
                        mul_a  = MUL_A_W'(rd.slope_difference);
                        mul_b  = MUL_B_W'(s_reg);
                        p_next = 64'(rd.start_offset);
                    end
                    5'd2:
                    begin
                        x21_next = 34'(rd.end_offset) - 34'(rd.start_offset)
                                   + 34'(prod >>> 30);
                        mul_a    = MUL_A_W'(rd.start_slope);
                        mul_b    = MUL_B_W'(s_reg);
                    end
                    5'd3:
                    begin
                        p_next = p_reg + 64'(prod >>> 30);
                        mul_a  = x21_reg;
                        mul_b  = MUL_B_W'(pa_reg);
                    end
                    5'd4:
                    begin
                        p_next = p_reg + 64'(prod >>> 24);
                        mul_a  = MUL_A_W'(rd.slope_difference);
                        mul_b  = MUL_B_W'(pkb_reg);
                    end
                    5'd5:
                    begin
                        p_next = p_reg - 64'(prod >>> 24);
                        mul_a  = x21_reg;
                        mul_b  = MUL_B_W'(pad_reg);
                    end
                    5'd6:
                    begin
                        pos_next = sat32(p_reg);
                        v0_next  = 64'(rd.start_slope) + 64'(prod >>> 24);
                        mul_a    = MUL_A_W'(rd.slope_difference);
                        mul_b    = MUL_B_W'(pa_reg);
                    end
                    5'd7:
                    begin
                        v0_next = v0_reg + 64'(prod >>> 24);
                        mul_a   = MUL_A_W'(rd.slope_difference);
                        mul_b   = MUL_B_W'(pkbd_reg);
                    end
                    5'd8:
                    begin
                        v0_next = v0_reg - 64'(prod >>> 24);
                        mul_a   = x21_reg;
                        mul_b   = MUL_B_W'(padd_reg);
                    end
                    5'd9:
                    begin
                        a0_next = 64'(prod >>> 24);
                        mul_a   = MUL_A_W'(rd.slope_difference);
                        mul_b   = MUL_B_W'(pad_reg);
                    end
                    5'd10:
                    begin
                        // Doubled first derivative term: one less bit of shift.
                        a0_next = a0_reg + 64'(prod >>> 23);
                        mul_a   = MUL_A_W'(rd.slope_difference);
                        mul_b   = MUL_B_W'(pkbdd_reg);
                    end
                    5'd11:
                    begin
                        a0_next = a0_reg - 64'(prod >>> 24);
                        mul_a   = MUL_A_W'($signed(v0_reg[47:16]));
                        mul_b   = MUL_B_W'(speed_scale_reg);
                    end
                    5'd12:
                    begin
                        q_next = 64'(prod);
                        mul_a  = MUL_A_W'(v0_reg[15:0]);
                        mul_b  = MUL_B_W'(speed_scale_reg);
                    end
                    5'd13:
                    begin
                        vel_next = sat32(mul_q16_fix(v0_reg, q_reg, 64'(prod),
                                                     speed_scale_reg));
                        mul_a    = MUL_A_W'($signed(a0_reg[47:16]));
                        mul_b    = MUL_B_W'(speed_scale_reg);
                    end
                    5'd14:
                    begin
                        q_next = 64'(prod);
                        mul_a  = MUL_A_W'(a0_reg[15:0]);
                        mul_b  = MUL_B_W'(speed_scale_reg);
                    end
                    5'd15:
                    begin
                        t_next = mul_q16_fix(a0_reg, q_reg, 64'(prod), speed_scale_reg);
                        mul_a  = MUL_A_W'(vel_reg);
                        mul_b  = MUL_B_W'(vel_reg);
                    end
                    5'd16:
                    begin
                        sq_sum    = {1'b0, sumv_reg} + {1'b0, prod[63:0]};
                        sumv_next = sq_sum[63:0];
                        ovv_next  = ovv_reg | sq_sum[64];
                        mul_a     = MUL_A_W'($signed(t_reg[47:16]));
                        mul_b     = MUL_B_W'(speed_scale_reg);
                    end
                    5'd17:
                    begin
                        q_next = 64'(prod);
                        mul_a  = MUL_A_W'(t_reg[15:0]);
                        mul_b  = MUL_B_W'(speed_scale_reg);
                    end
                    5'd18:
                    begin
                        acc_next = sat32(mul_q16_fix(t_reg, q_reg, 64'(prod),
                                                     speed_scale_reg));
                    end
                    5'd19:
                    begin
                        mul_a = MUL_A_W'(acc_reg);
                        mul_b = MUL_B_W'(acc_reg);
                    end
                    default:
                    begin
                        sq_sum     = {1'b0, suma_reg} + {1'b0, prod[63:0]};
                        suma_next  = sq_sum[63:0];
                        ova_next   = ova_reg | sq_sum[64];
                        step_next  = 5'd0;
                        state_next = is_last ? ST_ROOT : ST_EMIT;
                    end
                endcase
            end

            ST_ROOT:
            begin
                if (step_reg == 5'd0) begin
                    root_start = 1'b1;
                    step_next  = 5'd1;
                end
                else if (!rootv_busy && !roota_busy) begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || result.ready) begin
                    out_valid_next = 1'b1;
                    o_joint_next   = j_wide[2:0];
                    o_pos_next     = pos_reg;
                    o_vel_next     = vel_reg;
                    o_acc_next     = acc_reg;
                    o_last_next    = is_last;
                    if (is_last) begin
                        o_speed_next = ovv_reg ? 32'hFFFFFFFF : rootv;
                        o_accel_next = ova_reg ? 32'hFFFFFFFF : roota;
                        state_next   = ST_IDLE;
                    end
                    else begin
                        o_speed_next = 32'd0;
                        o_accel_next = 32'd0;
                        j_next       = j_reg + AW'(1);
                        step_next    = 5'd0;
                        state_next   = ST_JOINT;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            step_reg      <= 5'd0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_idx_reg <= ld_idx_next;
        ld_sp_reg  <= ld_sp_next;
        ld_sd_reg  <= ld_sd_next;
        ld_ed_reg  <= ld_ed_next;
        ld_ep_reg  <= ld_ep_next;
        tick_reg   <= tick_next;
        m1s_reg    <= m1s_next;

        s_reg     <= s_next;
        pw2_reg   <= pw2_next;
        pw3_reg   <= pw3_next;
        pw4_reg   <= pw4_next;
        pw5_reg   <= pw5_next;
        pw6_reg   <= pw6_next;
        pa_reg    <= pa_next;
        pad_reg   <= pad_next;
        padd_reg  <= padd_next;
        pkb_reg   <= pkb_next;
        pkbd_reg  <= pkbd_next;
        pkbdd_reg <= pkbdd_next;

        x21_reg  <= x21_next;
        p_reg    <= p_next;
        v0_reg   <= v0_next;
        a0_reg   <= a0_next;
        t_reg    <= t_next;
        q_reg    <= q_next;
        pos_reg  <= pos_next;
        vel_reg  <= vel_next;
        acc_reg  <= acc_next;
        sumv_reg <= sumv_next;
        suma_reg <= suma_next;
        ovv_reg  <= ovv_next;
        ova_reg  <= ova_next;

        o_joint_reg <= o_joint_next;
        o_pos_reg   <= o_pos_next;
        o_vel_reg   <= o_vel_next;
        o_acc_reg   <= o_acc_next;
        o_speed_reg <= o_speed_next;
        o_accel_reg <= o_accel_next;
        o_last_reg  <= o_last_next;
    end

    assign result.valid              = out_valid_reg;
    assign result.joint_number       = o_joint_reg;
    assign result.joint_position     = o_pos_reg;
    assign result.joint_velocity     = o_vel_reg;
    assign result.joint_acceleration = o_acc_reg;
    assign result.path_speed         = o_speed_reg;
    assign result.path_acceleration  = o_accel_reg;
    assign result.last               = o_last_reg;

endmodule

`default_nettype wire

// ===== tb/quintic_blend_trajectory_eval_test.sv =====
// ============================================================================
// Quintic blend trajectory evaluator testbench
// Loads joint blend coefficients and evaluates the blend at chosen and random
// ticks. Every result is checked field by field against a local fixed-point
// predictor. Both channels idle and stall at random, alone and then together.
// ============================================================================
`default_nettype none

module quintic_blend_trajectory_eval_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qbte_pkg::*;

    localparam int  JOINTS     = 8;
    localparam int  CYCLE_CAP  = 1000000;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [2:0]         joint_number;
        logic signed [31:0] joint_position;
        logic signed [31:0] joint_velocity;
        logic signed [31:0] joint_acceleration;
        logic [31:0]        path_speed;
        logic [31:0]        path_acceleration;
        logic               last;
    } motion_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    qbte_sample_if sample_ch ();
    qbte_result_if result_ch ();

    quintic_blend_trajectory_eval dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // Local copy of the block's registers and coefficient memory.
    logic [31:0]        blend_start_tick;
    logic [31:0]        blend_inv_duration;
    logic [30:0]        blend_speed_scale;
    logic [30:0]        blend_diameter;
    logic [3:0]         blend_joint_count;
    logic signed [31:0] coef_start_offset [JOINTS];
    logic signed [31:0] coef_start_slope  [JOINTS];
    logic signed [31:0] coef_end_offset   [JOINTS];
    logic signed [31:0] coef_slope_diff   [JOINTS];

    motion_t pending_motion[$];
    int      mismatches;
    int      sender_idle_pct;
    int      receiver_stall_pct;
    int      cycle_count;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic logic signed [31:0] clip32(input wide_t x);
        if (x > 128'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -128'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // floor(a * scale / 2^16); out-of-range operands become a large marker.
    function automatic wide_t scale_q16(input wide_t a, input logic [30:0] scale);
        wide_t hi;
        wide_t lo;
        wide_t s;
        s = scale;
        hi = a >>> 16;
        lo = a & 128'sh FFFF;
        if (scale == 31'd0) return 0;
        if (hi >= 128'sd2147483648) return 128'sd4611686018427387904;
        if (hi < -128'sd2147483648) return -128'sd4611686018427387904;
        return hi * s + ((lo * s) >>> 16);
    endfunction

    function automatic logic [31:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] vector_norm(input logic signed [31:0] v [JOINTS],
                                                input int n);
        wide_t sum;
        wide_t x;
        sum = 0;
        for (int j = 0; j < n; j++)
        begin
            x = v[j];
            sum = sum + x * x;
        end
        if (sum >= (128'sd1 <<< 64)) return 32'hFFFFFFFF;
        return int_sqrt(sum[63:0]);
    endfunction

    function automatic void store_blend(input logic [2:0] j, input logic signed [31:0] sp,
                                        input logic signed [31:0] sd,
                                        input logic signed [31:0] ed,
                                        input logic signed [31:0] ep);
        wide_t bd;
        wide_t w_sd;
        wide_t w_ed;
        wide_t w_ep;
        wide_t m1;
        wide_t m2;
        bd = blend_diameter;
        w_sd = sd;
        w_ed = ed;
        w_ep = ep;
        m1 = (w_sd * bd) >>> 16;
        m2 = (w_ed * bd) >>> 16;
        coef_start_offset[j] = sp;
        coef_start_slope[j]  = clip32(m1);
        coef_end_offset[j]   = clip32(w_ep - m2);
        coef_slope_diff[j]   = clip32(m2 - m1);
    endfunction

    function automatic void predict_motion(input logic [31:0] tick);
        logic [31:0]        d;
        logic [63:0]        prod;
        wide_t              s, s2, s3, s4, s5, s6;
        wide_t              pa, pad, padd, kb, kbd, kbdd;
        wide_t              b1, m1, b2, md, x21, p, v0, a0, ss;
        logic signed [31:0] pos [JOINTS];
        logic signed [31:0] vel [JOINTS];
        logic signed [31:0] acc [JOINTS];
        logic [31:0]        speed_norm, accel_norm;
        int                 n;
        motion_t            m;
        d = (tick > blend_start_tick) ? tick - blend_start_tick : 32'd0;
        prod = {32'd0, d} * {32'd0, blend_inv_duration};
        s = prod >> 2;
        if (s > (128'sd1 <<< 30)) s = 128'sd1 <<< 30;
        s2 = (s * s) >>> 30;
        s3 = (s2 * s) >>> 30;
        s4 = (s3 * s) >>> 30;
        s5 = (s4 * s) >>> 30;
        s6 = (s5 * s) >>> 30;
        pa   = (12 * s5 - 30 * s4 + 20 * s3) >>> 7;
        pad  = (60 * s4 - 120 * s3 + 60 * s2) >>> 7;
        padd = (240 * s3 - 360 * s2 + 120 * s) >>> 7;
        kb   = (15 * s6 - 45 * s5 + 45 * s4 - 15 * s3) >>> 7;
        kbd  = (90 * s5 - 225 * s4 + 180 * s3 - 45 * s2) >>> 7;
        kbdd = (450 * s4 - 900 * s3 + 540 * s2 - 90 * s) >>> 7;
        n = blend_joint_count;
        if (n == 0) n = 1;
        if (n > JOINTS) n = JOINTS;
        for (int j = 0; j < n; j++)
        begin
            b1 = coef_start_offset[j];
            m1 = coef_start_slope[j];
            b2 = coef_end_offset[j];
            md = coef_slope_diff[j];
            x21 = b2 - b1 + ((md * s) >>> 30);
            p  = b1 + ((m1 * s) >>> 30) + ((x21 * pa) >>> 24) - ((md * kb) >>> 24);
            v0 = m1 + ((x21 * pad) >>> 24) + ((md * pa) >>> 24) - ((md * kbd) >>> 24);
            a0 = ((x21 * padd) >>> 24) + ((md * 2 * pad) >>> 24) - ((md * kbdd) >>> 24);
            ss = scale_q16(a0, blend_speed_scale);
            pos[j] = clip32(p);
            vel[j] = clip32(scale_q16(v0, blend_speed_scale));
            acc[j] = clip32(scale_q16(ss, blend_speed_scale));
        end
        speed_norm = vector_norm(vel, n);
        accel_norm = vector_norm(acc, n);
        for (int j = 0; j < n; j++)
        begin
            m.joint_number       = j[2:0];
            m.joint_position     = pos[j];
            m.joint_velocity     = vel[j];
            m.joint_acceleration = acc[j];
            m.last               = (j + 1 == n);
            m.path_speed         = m.last ? speed_norm : 32'd0;
            m.path_acceleration  = m.last ? accel_norm : 32'd0;
            pending_motion.push_back(m);
        end
    endfunction

    task automatic send_item(input logic mode, input logic [2:0] j,
                             input logic signed [31:0] sp, input logic signed [31:0] sd,
                             input logic signed [31:0] ed, input logic signed [31:0] ep,
                             input logic [31:0] tick);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
        end
        sample_ch.valid           <= 1'b1;
        sample_ch.mode            <= mode;
        sample_ch.joint_index     <= j;
        sample_ch.start_position  <= sp;
        sample_ch.start_heading   <= sd;
        sample_ch.end_heading     <= ed;
        sample_ch.end_position    <= ep;
        sample_ch.sample_tick     <= tick;
        @(posedge clk);
        while (!sample_ch.ready) @(posedge clk);
        if (mode == MODE_LOAD)
            store_blend(j, sp, sd, ed, ep);
        else
            predict_motion(tick);
    endtask

    task automatic load_joint(input logic [2:0] j, input logic signed [31:0] sp,
                              input logic signed [31:0] sd, input logic signed [31:0] ed,
                              input logic signed [31:0] ep);
        send_item(MODE_LOAD, j, sp, sd, ed, ep, $urandom);
    endtask

    task automatic evaluate_at(input logic [31:0] tick);
        send_item(MODE_EVAL, 3'($urandom), $urandom, $urandom, $urandom, $urandom, tick);
    endtask

    // Drains outstanding results and leaves room for a load still in flight.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_motion.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (r)
            REG_START_TICK:       blend_start_tick   = v;
            REG_INVERSE_DURATION: blend_inv_duration = v;
            REG_SPEED_SCALE:      blend_speed_scale  = v[30:0];
            REG_BLEND_DIAMETER:   blend_diameter     = v[30:0];
            REG_ACTIVE_JOINTS:    blend_joint_count  = v[3:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_q16();
        logic signed [31:0] v;
        if ($urandom_range(3) == 0) return $urandom;
        v = $urandom_range(0, 32'h3FFFFF);
        return v - 32'sh200000;
    endfunction

    task automatic test_directed_extremes();
        settle();
        write_reg(REG_BLEND_DIAMETER, 32'h0002_0000);
        write_reg(REG_SPEED_SCALE, 32'h0001_0000);
        write_reg(REG_START_TICK, 32'd1000);
        write_reg(REG_INVERSE_DURATION, 32'd4294967);
        write_reg(REG_ACTIVE_JOINTS, 32'd8);
        for (int j = 0; j < 6; j++)
            load_joint(3'(j), pick_q16(), pick_q16(), pick_q16(), pick_q16());
        load_joint(3'd6, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000);
        load_joint(3'd7, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        evaluate_at(32'd0);
        evaluate_at(32'd1000);
        evaluate_at(32'd1500);
        evaluate_at(32'd2000);
        evaluate_at(32'hFFFFFFFF);
        settle();
        write_reg(REG_INVERSE_DURATION, 32'd0);
        evaluate_at(32'hFFFFFFFF);
        settle();
        write_reg(REG_START_TICK, 32'hFFFFFFFF);
        write_reg(REG_INVERSE_DURATION, 32'hFFFFFFFF);
        evaluate_at(32'hFFFFFFFF);
        evaluate_at(32'd0);
        settle();
        write_reg(REG_START_TICK, 32'd0);
        write_reg(REG_SPEED_SCALE, 32'hFFFFFFFF);
        write_reg(REG_BLEND_DIAMETER, 32'hFFFFFFFF);
        load_joint(3'd3, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
        evaluate_at(32'd1);
        settle();
        write_reg(REG_SPEED_SCALE, 32'd0);
        evaluate_at(32'd2);
        settle();
    endtask

    task automatic test_active_joint_counts();
        logic [31:0] counts [4] = '{32'd0, 32'd1, 32'd9, 32'd15};
        write_reg(REG_SPEED_SCALE, 32'h0000_8000);
        write_reg(REG_INVERSE_DURATION, 32'h0100_0000);
        foreach (counts[i])
        begin
            settle();
            write_reg(REG_ACTIVE_JOINTS, counts[i]);
            evaluate_at($urandom_range(0, 400));
        end
        settle();
    endtask

    task automatic test_random_blends();
        int idle_pct  [4] = '{0, 55, 0, 10};
        int stall_pct [4] = '{0, 0, 55, 10};
        int span;
        int offset;
        for (int ph = 0; ph < 4; ph++)
        begin
            for (int sub = 0; sub < 2; sub++)
            begin
                settle();
                sender_idle_pct    = idle_pct[ph];
                receiver_stall_pct = stall_pct[ph];
                span = $urandom_range(16, 5000);
                write_reg(REG_START_TICK, $urandom);
                write_reg(REG_INVERSE_DURATION, 32'hFFFFFFFF / span);
                write_reg(REG_SPEED_SCALE,
                          ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h40000));
                write_reg(REG_BLEND_DIAMETER,
                          ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 32'h40000));
                write_reg(REG_ACTIVE_JOINTS, $urandom_range(0, 15));
                for (int k = 0; k < 20; k++)
                begin
                    if ($urandom_range(3) == 0)
                        load_joint(3'($urandom), pick_q16(), pick_q16(), pick_q16(),
                                   pick_q16());
                    else if ($urandom_range(9) == 0)
                        evaluate_at($urandom);
                    else
                    begin
                        offset = $urandom_range(0, span * 3 / 2) - span / 4;
                        evaluate_at(blend_start_tick + offset);
                    end
                end
            end
        end
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        settle();
    endtask

    // Result checker and receiver stall generator.
    always @(posedge clk)
    begin
        motion_t got;
        motion_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.joint_number       = result_ch.joint_number;
            got.joint_position     = result_ch.joint_position;
            got.joint_velocity     = result_ch.joint_velocity;
            got.joint_acceleration = result_ch.joint_acceleration;
            got.path_speed         = result_ch.path_speed;
            got.path_acceleration  = result_ch.path_acceleration;
            got.last               = result_ch.last;
            if (pending_motion.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected transaction: joint %0d", $realtime, got.joint_number);
            end
            else
            begin
                want = pending_motion.pop_front();
                if (got.joint_number != want.joint_number)
                    $display("%0t joint_number: expected %0d actual %0d", $realtime,
                             want.joint_number, got.joint_number);
                if (got.joint_position != want.joint_position)
                    $display("%0t joint_position: expected %0d actual %0d", $realtime,
                             want.joint_position, got.joint_position);
                if (got.joint_velocity != want.joint_velocity)
                    $display("%0t joint_velocity: expected %0d actual %0d", $realtime,
                             want.joint_velocity, got.joint_velocity);
                if (got.joint_acceleration != want.joint_acceleration)
                    $display("%0t joint_acceleration: expected %0d actual %0d", $realtime,
                             want.joint_acceleration, got.joint_acceleration);
                if (got.path_speed != want.path_speed)
                    $display("%0t path_speed: expected %0d actual %0d", $realtime,
                             want.path_speed, got.path_speed);
                if (got.path_acceleration != want.path_acceleration)
                    $display("%0t path_acceleration: expected %0d actual %0d", $realtime,
                             want.path_acceleration, got.path_acceleration);
                if (got.last != want.last)
                    $display("%0t last: expected %0b actual %0b", $realtime,
                             want.last, got.last);
                if (got != want) mismatches++;
            end
        end
        result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("quintic_blend_trajectory_eval_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        rst_n                     = 1'b0;
        cfg_write                 = 1'b0;
        cfg_index                 = '0;
        cfg_data                  = '0;
        sample_ch.valid           = 1'b0;
        sample_ch.mode            = MODE_LOAD;
        sample_ch.joint_index     = '0;
        sample_ch.start_position  = '0;
        sample_ch.start_heading   = '0;
        sample_ch.end_heading     = '0;
        sample_ch.end_position    = '0;
        sample_ch.sample_tick     = '0;
        result_ch.ready           = 1'b0;
        cycle_count               = 0;
        mismatches                = 0;
        sender_idle_pct           = 0;
        receiver_stall_pct        = 0;
        blend_start_tick          = 32'd0;
        blend_inv_duration        = 32'd0;
        blend_speed_scale         = 31'd0;
        blend_diameter            = 31'd0;
        blend_joint_count         = ACTIVE_JOINTS_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_active_joint_counts();
        test_random_blends();
        while (pending_motion.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && pending_motion.size() == 0)
            $display("quintic_blend_trajectory_eval_test OK");
        else
            $display("quintic_blend_trajectory_eval_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
